FILE: hdl/ucjkrf_pkg.sv
// ----------------------------------------------------------------------------
// ucjkrf_pkg: shared types and constants of the CJK / Latin record filter
// Byte classes, verdict codes, register indexes and item/result structs.
// ----------------------------------------------------------------------------
package ucjkrf_pkg;

  // UTF-8 byte classes of interest
  localparam logic [7:0] LEAD_LO  = 8'hE4;
  localparam logic [7:0] LEAD_HI  = 8'hE9;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h5A;
  localparam logic [7:0] LOWER_LO = 8'h61;
  localparam logic [7:0] LOWER_HI = 8'h7A;

  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned RUN_W   = 8;

  localparam logic [TOTAL_W-1:0] CJK_LIMIT_RST = 16'd512;
  localparam logic [RUN_W-1:0]   RUN_LIMIT_RST = 8'd5;
  localparam logic [RUN_W-1:0]   RUN_MAX       = 8'hFF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CJK_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 1'b1;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_EMPTY_Q   = 3'd1,
    VERDICT_EMPTY_A   = 3'd2,
    VERDICT_CJK_HIGH  = 3'd3,
    VERDICT_LONG_RUN  = 3'd4
  } verdict_e;

  // lookahead window contents: nothing, a lead byte, lead plus one continuation
  typedef enum logic [1:0] {
    FILL_NONE      = 2'd0,
    FILL_LEAD      = 2'd1,
    FILL_LEAD_CONT = 2'd2
  } fill_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       field_end;
    logic       answer_field;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] cjk_limit;
    logic [RUN_W-1:0]   run_limit;
  } cfg_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [TOTAL_W-1:0] cjk_total;
  } result_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= LEAD_LO) && (b <= LEAD_HI);
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= CONT_LO) && (b <= CONT_HI);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= UPPER_LO) && (b <= UPPER_HI)) || ((b >= LOWER_LO) && (b <= LOWER_HI));
  endfunction

endpackage

FILE: hdl/ucjkrf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ucjkrf_cfg_regs: configuration registers
// Holds the CJK limit and the letter run limit, written by index.
// ----------------------------------------------------------------------------
module ucjkrf_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ucjkrf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ucjkrf_pkg::TOTAL_W-1:0]       cfg_data_i,
  output ucjkrf_pkg::cfg_t                     cfg_o
);
  import ucjkrf_pkg::*;

  logic [TOTAL_W-1:0] cjk_limit_q;
  logic [RUN_W-1:0]   run_limit_q;
  logic               wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cjk_limit_q <= CJK_LIMIT_RST;
      run_limit_q <= RUN_LIMIT_RST;
    end else if (wr_en) begin
      unique case (cfg_index_i)
        CFG_CJK_LIMIT: cjk_limit_q <= cfg_data_i;
        CFG_RUN_LIMIT: run_limit_q <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.cjk_limit = cjk_limit_q;
  assign cfg_o.run_limit = run_limit_q;

endmodule

FILE: hdl/ucjkrf_scan.sv
// ----------------------------------------------------------------------------
// ucjkrf_scan: greedy UTF-8 scan and record state
// Tracks the CJK lookahead window, CJK total, letter run and field flags,
// and forms the verdict when an answer field closes.
// ----------------------------------------------------------------------------
module ucjkrf_scan #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ucjkrf_pkg::in_item_t  item_i,
  input  logic                  item_valid_i,
  input  logic                  advance_i,
  input  ucjkrf_pkg::cfg_t      cfg_i,
  output logic                  res_valid_o,
  output ucjkrf_pkg::result_t   res_o
);
  import ucjkrf_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  fill_e                 fill_q, fill_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [RUN_W-1:0]      run_q, run_d;
  logic                  exceed_q, exceed_d;
  logic                  q_nonempty_q, q_nonempty_d;
  logic                  a_nonempty_q, a_nonempty_d;

  logic                  b_lead, b_cont, b_letter, present;
  logic                  take_b, run_clr, cjk_inc;
  logic [RUN_W-1:0]      run_base, run_inc;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  emit;

  assign present  = item_i.byte_present;
  assign b_lead   = is_lead(item_i.text_byte);
  assign b_cont   = is_cont(item_i.text_byte);
  assign b_letter = is_letter(item_i.text_byte);

  // window next state
  always_comb begin
    fill_d = fill_q;
    if (present) begin
      unique case (fill_q)
        FILL_NONE:      fill_d = b_lead ? FILL_LEAD : FILL_NONE;
        FILL_LEAD:      fill_d = b_cont ? FILL_LEAD_CONT : (b_lead ? FILL_LEAD : FILL_NONE);
        FILL_LEAD_CONT: fill_d = (!b_cont && b_lead) ? FILL_LEAD : FILL_NONE;
        default:        fill_d = FILL_NONE;
      endcase
    end
    if (item_i.field_end) begin
      fill_d = FILL_NONE;
    end
  end

  // window actions: dropped window bytes are never letters, so they only clear the run
  always_comb begin
    take_b  = 1'b0;
    run_clr = 1'b0;
    cjk_inc = 1'b0;
    if (present) begin
      unique case (fill_q)
        FILL_NONE: begin
          take_b = !b_lead;
        end
        FILL_LEAD: begin
          run_clr = !b_cont;
          take_b  = !b_cont && !b_lead;
        end
        FILL_LEAD_CONT: begin
          run_clr = 1'b1;
          cjk_inc = b_cont;
          take_b  = !b_cont && !b_lead;
        end
        default: ;
      endcase
    end
  end

  // counters and flags
  always_comb begin
    run_base = run_clr ? '0 : run_q;
    run_inc  = (run_base != RUN_MAX) ? run_base + RUN_W'(1) : run_base;
    run_d    = run_base;
    exceed_d = exceed_q;
    if (take_b) begin
      if (b_letter) begin
        run_d = run_inc;
        if (run_inc >= cfg_i.run_limit) begin
          exceed_d = 1'b1;
        end
      end else begin
        run_d = '0;
      end
    end
    if (item_i.field_end) begin
      run_d = '0;
    end

    cnt_d = cnt_q;
    if (cjk_inc && (cnt_q != {COUNT_BITS{1'b1}})) begin
      cnt_d = cnt_q + COUNT_BITS'(1);
    end

    q_nonempty_d = q_nonempty_q | (present & !item_i.answer_field);
    a_nonempty_d = a_nonempty_q | (present &  item_i.answer_field);
  end

  assign emit    = item_i.field_end && item_i.answer_field;
  assign cnt_ext = CMP_W'(cnt_d);

  always_comb begin
    if (!q_nonempty_d) begin
      res_o.verdict = VERDICT_EMPTY_Q;
    end else if (!a_nonempty_d) begin
      res_o.verdict = VERDICT_EMPTY_A;
    end else if (cnt_ext > CMP_W'(cfg_i.cjk_limit)) begin
      res_o.verdict = VERDICT_CJK_HIGH;
    end else if (exceed_d) begin
      res_o.verdict = VERDICT_LONG_RUN;
    end else begin
      res_o.verdict = VERDICT_ACCEPT;
    end
    res_o.cjk_total = (cnt_ext > CMP_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                         : cnt_ext[TOTAL_W-1:0];
  end

  assign res_valid_o = item_valid_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= FILL_NONE;
      cnt_q        <= '0;
      run_q        <= '0;
      exceed_q     <= 1'b0;
      q_nonempty_q <= 1'b0;
      a_nonempty_q <= 1'b0;
    end else if (advance_i) begin
      if (emit) begin
        // record closed: start the next one clean
        fill_q       <= FILL_NONE;
        cnt_q        <= '0;
        run_q        <= '0;
        exceed_q     <= 1'b0;
        q_nonempty_q <= 1'b0;
        a_nonempty_q <= 1'b0;
      end else begin
        fill_q       <= fill_d;
        cnt_q        <= cnt_d;
        run_q        <= run_d;
        exceed_q     <= exceed_d;
        q_nonempty_q <= q_nonempty_d;
        a_nonempty_q <= a_nonempty_d;
      end
    end
  end

  a_field_end_clears_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.field_end |=> fill_q == FILL_NONE && run_q == '0)
    else $error("window or letter run survived a field end");

  a_record_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && emit |=> cnt_q == '0 && !exceed_q && !q_nonempty_q && !a_nonempty_q)
    else $error("record state not cleared after verdict");

  a_cjk_needs_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !emit && (cnt_d != cnt_q) |=> fill_q == FILL_NONE)
    else $error("CJK count moved without a complete character");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(cnt_q) && $stable(run_q) && $stable(fill_q))
    else $error("record state changed without an advancing item");

endmodule

FILE: hdl/utf8_cjk_latin_record_filter_unit.sv
// ----------------------------------------------------------------------------
// utf8_cjk_latin_record_filter_unit: CJK / Latin record filter top level
// Input register, scan stage and result register around a per-record verdict.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | tdata: text_byte, byte_present; tlast: field_end;
//            |           | tuser: answer_field
//   m_axis   | out       | tdata: verdict, cjk_total (one per record)
//   cfg      | in        | index 0 cjk_limit, index 1 letter_run_limit
//
// One byte per cycle while no held result stalls the scan stage; each item
// is scanned from the input register and its verdict is loaded into the
// result register. The scan stage's registered state feedback sets that rate.
// Reset clears the record state and loads the limits 512 and 5.
// A held result stalls the scan stage only when a second verdict is due.
// ----------------------------------------------------------------------------
module utf8_cjk_latin_record_filter_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: [7:0] text_byte, [8] byte_present, [15:9] zero
  input  logic [ucjkrf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                  s_axis_tlast,
  // tuser: [0] answer_field
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: [2:0] verdict, [18:3] cjk_total, [23:19] zero
  output logic [ucjkrf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ucjkrf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ucjkrf_pkg::TOTAL_W-1:0]        cfg_data_i
);
  import ucjkrf_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  cfg_t     cfg;
  in_item_t in_d, in_q;
  logic     in_valid_q;
  logic     advance;
  logic     res_valid;
  result_t  res, out_q;
  logic     out_valid_q;
  logic     out_free;
  logic     load_out;

  ucjkrf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_d.text_byte    = s_axis_tdata[7:0];
  assign in_d.byte_present = s_axis_tdata[8];
  assign in_d.field_end    = s_axis_tlast;
  assign in_d.answer_field = s_axis_tuser;

  ucjkrf_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (in_q),
    .item_valid_i (in_valid_q),
    .advance_i    (advance),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // scan stage moves unless it has a verdict and the result register is still held
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!res_valid || out_free);
  assign load_out      = advance && res_valid;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q.cjk_total, out_q.verdict};

  a_in_reg_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register overwritten before its item was scanned");

  a_verdict_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && out_q == $past(res))
    else $error("verdict not captured in the result register");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !load_out)
    else $error("result register reloaded while its transfer is pending");

endmodule
